>>> design/cor_pkg.sv
// Shared types, constants and point-order functions of the circle outline rasterizer.
package cor_pkg;

  localparam int REG_W   = 13;
  localparam int COLOR_W = 24;
  localparam int INDEX_W = 24;
  localparam int PT_W    = 3;

  localparam logic [REG_W-1:0] FRAME_W_RST = 13'd640;
  localparam logic [REG_W-1:0] FRAME_H_RST = 13'd480;

  // Configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_STEP,
    JOB_IDLE
  } job_kind_e;

  typedef struct packed {
    job_kind_e kind;
    logic      finished;
  } job_ctl_t;

  typedef struct packed {
    logic visible;
    logic last;
    logic finished;
  } pt_ctl_t;

  typedef struct packed {
    logic swap;
    logic neg_x;
    logic neg_y;
  } pt_sel_t;

  // Index of the final point of a job
  function automatic logic [PT_W-1:0] last_point(job_kind_e kind);
    logic [PT_W-1:0] n;
    case (kind)
      JOB_START: n = 3'd3;
      JOB_STEP:  n = 3'd7;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // Octant mapping of point k; the start job takes the left axis point as fourth
  function automatic pt_sel_t point_sel(job_kind_e kind, logic [PT_W-1:0] k);
    pt_sel_t s;
    s.swap  = k[0];
    s.neg_y = k[1];
    s.neg_x = k[2];
    if (kind == JOB_START && k == 3'd3) begin
      s.swap  = 1'b1;
      s.neg_x = 1'b1;
      s.neg_y = 1'b0;
    end
    return s;
  endfunction

endpackage

>>> design/cor_ctrl.sv
// Circle state and at most one Bresenham circle decision update per accepted transaction.
module cor_ctrl #(
  parameter int COORD_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     cmd_i,
  input  logic [COORD_BITS-1:0]    center_x_i,
  input  logic [COORD_BITS-1:0]    center_y_i,
  input  logic [COORD_BITS-1:0]    radius_i,
  input  logic [cor_pkg::COLOR_W-1:0] color_i,
  output cor_pkg::job_ctl_t        job_ctl_o,
  output logic [COORD_BITS-1:0]    job_cx_o,
  output logic [COORD_BITS-1:0]    job_cy_o,
  output logic [COORD_BITS:0]      job_u_o,
  output logic [COORD_BITS:0]      job_v_o,
  output logic [cor_pkg::COLOR_W-1:0] job_color_o
);
  import cor_pkg::*;

  localparam int SW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 8;

  logic [COORD_BITS-1:0] ctr_x_q, ctr_x_d, ctr_y_q, ctr_y_d;
  logic [COLOR_W-1:0]    pen_color_q, pen_color_d;
  logic [SW-1:0]         step_x_q, step_x_d, step_y_q, step_y_d;
  logic [DW-1:0]         decision_q, decision_d;
  logic                  done_q, done_d;
  job_kind_e             kind;
  logic [DW-1:0]         xs, ys;
  logic                  dec_pos;

  assign xs      = DW'(step_x_q);
  assign ys      = DW'(step_y_q);
  assign dec_pos = !decision_q[DW-1] && (decision_q != '0);

  // Next circle state for the incoming transaction
  always_comb begin
    ctr_x_d     = ctr_x_q;
    ctr_y_d     = ctr_y_q;
    pen_color_d = pen_color_q;
    step_x_d    = step_x_q;
    step_y_d    = step_y_q;
    decision_d  = decision_q;
    done_d      = done_q;
    kind        = JOB_IDLE;
    if (cmd_i == CMD_START) begin
      ctr_x_d     = center_x_i;
      ctr_y_d     = center_y_i;
      pen_color_d = color_i;
      step_x_d    = '0;
      step_y_d    = SW'(radius_i);
      decision_d  = DW'(3) - (DW'(radius_i) << 1);
      done_d      = (radius_i == '0);
      kind        = JOB_START;
    end else if (done_q || (step_x_q > step_y_q)) begin
      done_d = 1'b1;
      kind   = JOB_IDLE;
    end else begin
      if (dec_pos) begin
        decision_d = decision_q + ((xs - ys) << 2) + DW'(10);
        step_y_d   = step_y_q - SW'(1);
      end else begin
        decision_d = decision_q + (xs << 2) + DW'(6);
      end
      step_x_d = step_x_q + SW'(1);
      done_d   = step_x_d > step_y_d;
      kind     = JOB_STEP;
    end
  end

  // Hand the updated state to the point walker
  always_comb begin
    job_ctl_o.kind     = kind;
    job_ctl_o.finished = done_d;
    job_cx_o           = ctr_x_d;
    job_cy_o           = ctr_y_d;
    job_u_o            = step_x_d;
    job_v_o            = step_y_d;
    job_color_o        = pen_color_d;
  end

  // Commit state on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q     <= '0;
      ctr_y_q     <= '0;
      pen_color_q <= '0;
      step_x_q    <= '0;
      step_y_q    <= '0;
      decision_q  <= '0;
      done_q      <= 1'b1;
    end else if (accept_i) begin
      ctr_x_q     <= ctr_x_d;
      ctr_y_q     <= ctr_y_d;
      pen_color_q <= pen_color_d;
      step_x_q    <= step_x_d;
      step_y_q    <= step_y_d;
      decision_q  <= decision_d;
      done_q      <= done_d;
    end
  end

endmodule

>>> design/cor_walk.sv
// Job register and point walker: one octant point per cycle while the point register can take it, offset and clipped.
module cor_walk #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  cor_pkg::job_ctl_t           job_ctl_i,
  input  logic [COORD_BITS-1:0]       job_cx_i,
  input  logic [COORD_BITS-1:0]       job_cy_i,
  input  logic [COORD_BITS:0]         job_u_i,
  input  logic [COORD_BITS:0]         job_v_i,
  input  logic [cor_pkg::COLOR_W-1:0] job_color_i,
  input  logic [cor_pkg::REG_W-1:0]   frame_w_i,
  input  logic [cor_pkg::REG_W-1:0]   frame_h_i,
  input  logic                        out_free_i,
  output logic                        job_free_o,
  output logic                        pt_valid_o,
  output cor_pkg::pt_ctl_t            pt_ctl_o,
  output logic [COORD_BITS:0]         pt_x_o,
  output logic [COORD_BITS:0]         pt_y_o,
  output logic [cor_pkg::COLOR_W-1:0] pt_color_o
);
  import cor_pkg::*;

  localparam int CW   = COORD_BITS + 2;
  localparam int CMPW = (COORD_BITS + 1 > REG_W) ? COORD_BITS + 1 : REG_W;

  logic                  job_valid_q;
  job_ctl_t              job_ctl_q;
  logic [COORD_BITS-1:0] cx_q, cy_q;
  logic [COORD_BITS:0]   u_q, v_q;
  logic [COLOR_W-1:0]    color_q;
  logic [PT_W-1:0]       idx_q;

  logic                  pt_valid_q;
  pt_ctl_t               pt_ctl_q, pt_ctl_d;
  logic [COORD_BITS:0]   pt_x_q, pt_y_q;
  logic [COLOR_W-1:0]    pt_color_q, pt_color_d;

  logic                  pt_free, emit, last_pt;
  pt_sel_t               sel;
  logic [CW-1:0]         off_x, off_y, px, py;
  logic                  in_frame;

  assign pt_free    = !pt_valid_q || out_free_i;
  assign emit       = job_valid_q && pt_free;
  assign last_pt    = (idx_q == last_point(job_ctl_q.kind));
  assign job_free_o = !job_valid_q || (emit && last_pt);

  // Hold the job and advance the point counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (accept_i) begin
      job_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (emit && last_pt) begin
      job_valid_q <= 1'b0;
    end else if (emit) begin
      idx_q <= idx_q + PT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      job_ctl_q <= job_ctl_i;
      cx_q      <= job_cx_i;
      cy_q      <= job_cy_i;
      u_q       <= job_u_i;
      v_q       <= job_v_i;
      color_q   <= job_color_i;
    end
  end

  // Place the current point and clip it to the frame
  always_comb begin
    sel   = point_sel(job_ctl_q.kind, idx_q);
    off_x = CW'(sel.swap ? v_q : u_q);
    off_y = CW'(sel.swap ? u_q : v_q);
    px    = sel.neg_x ? (CW'(cx_q) - off_x) : (CW'(cx_q) + off_x);
    py    = sel.neg_y ? (CW'(cy_q) - off_y) : (CW'(cy_q) + off_y);
    in_frame = !px[CW-1] && !py[CW-1]
             && (CMPW'(px[CW-2:0]) < CMPW'(frame_w_i))
             && (CMPW'(py[CW-2:0]) < CMPW'(frame_h_i));
    pt_ctl_d.visible  = in_frame && (job_ctl_q.kind != JOB_IDLE);
    pt_ctl_d.last     = last_pt;
    pt_ctl_d.finished = job_ctl_q.finished;
    pt_color_d        = pt_ctl_d.visible ? color_q : '0;
  end

  // Point register between walker and pixel stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_valid_q <= 1'b0;
    end else if (pt_free) begin
      pt_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pt_ctl_q   <= pt_ctl_d;
      pt_x_q     <= px[CW-2:0];
      pt_y_q     <= py[CW-2:0];
      pt_color_q <= pt_color_d;
    end
  end

  assign pt_valid_o = pt_valid_q;
  assign pt_ctl_o   = pt_ctl_q;
  assign pt_x_o     = pt_x_q;
  assign pt_y_o     = pt_y_q;
  assign pt_color_o = pt_color_q;

endmodule

>>> design/cor_pixel.sv
// Pixel stage: linear index width*y+x and the output register.
module cor_pixel #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pt_valid_i,
  input  cor_pkg::pt_ctl_t            pt_ctl_i,
  input  logic [COORD_BITS:0]         pt_x_i,
  input  logic [COORD_BITS:0]         pt_y_i,
  input  logic [cor_pkg::COLOR_W-1:0] pt_color_i,
  input  logic [cor_pkg::REG_W-1:0]   frame_w_i,
  input  logic                        out_stall_i,
  output logic                        out_free_o,
  output logic                        out_valid_o,
  output logic                        visible_o,
  output logic [cor_pkg::INDEX_W-1:0] pixel_index_o,
  output logic [cor_pkg::COLOR_W-1:0] pixel_value_o,
  output logic                        last_o,
  output logic                        finished_o
);
  import cor_pkg::*;

  localparam int MW = (COORD_BITS + 1 + REG_W > INDEX_W) ? COORD_BITS + 1 + REG_W : INDEX_W;

  logic               out_valid_q;
  pt_ctl_t            ctl_q;
  logic [INDEX_W-1:0] index_q, index_d;
  logic [COLOR_W-1:0] value_q;
  logic [MW-1:0]      lin;

  assign out_free_o = !out_valid_q || !out_stall_i;

  // Row-major offset, wrapped to the index width
  always_comb begin
    lin     = (MW'(frame_w_i) * MW'(pt_y_i)) + MW'(pt_x_i);
    index_d = pt_ctl_i.visible ? lin[INDEX_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free_o) begin
      out_valid_q <= pt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && pt_valid_i) begin
      ctl_q   <= pt_ctl_i;
      index_q <= index_d;
      value_q <= pt_color_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign visible_o     = ctl_q.visible;
  assign pixel_index_o = index_q;
  assign pixel_value_o = value_q;
  assign last_o        = ctl_q.last;
  assign finished_o    = ctl_q.finished;

endmodule

>>> design/circle_outline_rasterizer.sv
// Path: job register, point register, output register. Throughput: one result per
// cycle from the point walker while the output is not stalled; a start gives 4 points,
// a step 8, a step on a finished circle 1; the next transaction is taken in the cycle
// its predecessor's last point leaves the job register.
// Reset: frame 640 x 480, no circle pending, so steps report finished; pipeline empty.
module circle_outline_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [cor_pkg::REG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [COORD_BITS-1:0]       center_x_i,
  input  logic [COORD_BITS-1:0]       center_y_i,
  input  logic [COORD_BITS-1:0]       radius_i,
  input  logic [cor_pkg::COLOR_W-1:0] color_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        visible_o,
  output logic [cor_pkg::INDEX_W-1:0] pixel_index_o,
  output logic [cor_pkg::COLOR_W-1:0] pixel_value_o,
  output logic                        last_o,
  output logic                        finished_o
);
  import cor_pkg::*;

  logic [REG_W-1:0]      frame_w_q, frame_h_q;
  logic                  accept, job_free, out_free, pt_valid;
  job_ctl_t              job_ctl;
  logic [COORD_BITS-1:0] job_cx, job_cy;
  logic [COORD_BITS:0]   job_u, job_v, pt_x, pt_y;
  logic [COLOR_W-1:0]    job_color, pt_color;
  pt_ctl_t               pt_ctl;

  // Frame size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q <= FRAME_W_RST;
      frame_h_q <= FRAME_H_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_w_q <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_h_q <= cfg_data_i;
        default:          frame_w_q <= frame_w_q;
      endcase
    end
  end

  // Take a transaction once the job register frees up
  assign in_stall_o = !job_free;
  assign accept     = in_valid_i && job_free;

  cor_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_i    (radius_i),
    .color_i     (color_i),
    .job_ctl_o   (job_ctl),
    .job_cx_o    (job_cx),
    .job_cy_o    (job_cy),
    .job_u_o     (job_u),
    .job_v_o     (job_v),
    .job_color_o (job_color)
  );

  cor_walk #(.COORD_BITS(COORD_BITS)) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .job_ctl_i   (job_ctl),
    .job_cx_i    (job_cx),
    .job_cy_i    (job_cy),
    .job_u_i     (job_u),
    .job_v_i     (job_v),
    .job_color_i (job_color),
    .frame_w_i   (frame_w_q),
    .frame_h_i   (frame_h_q),
    .out_free_i  (out_free),
    .job_free_o  (job_free),
    .pt_valid_o  (pt_valid),
    .pt_ctl_o    (pt_ctl),
    .pt_x_o      (pt_x),
    .pt_y_o      (pt_y),
    .pt_color_o  (pt_color)
  );

  cor_pixel #(.COORD_BITS(COORD_BITS)) u_pixel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pt_valid_i    (pt_valid),
    .pt_ctl_i      (pt_ctl),
    .pt_x_i        (pt_x),
    .pt_y_i        (pt_y),
    .pt_color_i    (pt_color),
    .frame_w_i     (frame_w_q),
    .out_stall_i   (out_stall_i),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .visible_o     (visible_o),
    .pixel_index_o (pixel_index_o),
    .pixel_value_o (pixel_value_o),
    .last_o        (last_o),
    .finished_o    (finished_o)
  );

endmodule
